>>> hdl/box_mean_filter_core_defines.svh
// ----------------------------------------------------------------------------
// box_mean_filter_core_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BOX_MEAN_FILTER_CORE_DEFINES_SVH
`define BOX_MEAN_FILTER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define BMF_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define BMF_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

>>> hdl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Types and constants of the box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none
package bmf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd3;

    localparam int DIV_STEPS = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FLUSH,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } bmf_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic acc_clr;
        logic div_load;
        logic div_step;
        logic out_load;
        logic last;
    } bmf_cmd_t;

    typedef struct packed {
        logic slot_free;
    } bmf_status_t;

endpackage
`default_nettype wire

>>> hdl/bmf_if.sv
// ----------------------------------------------------------------------------
// bmf_if
// Valid/ready channels of the box mean filter.
// ----------------------------------------------------------------------------
`default_nettype none
interface bmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       drain;
    modport source (output valid, sample, drain, input ready);
    modport sink   (input valid, sample, drain, output ready);
endinterface

interface bmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] filtered;
    logic       last;
    modport source (output valid, filtered, last, input ready);
    modport sink   (input valid, filtered, last, output ready);
endinterface

interface bmf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/bmf_datapath.sv
// ----------------------------------------------------------------------------
// bmf_datapath
// Line store, window accumulator, rounding divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module bmf_datapath
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_WINDOW   = 7,
    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS * MAX_WINDOW,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int NW_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1),
    localparam int ACC_W  = $clog2(MAX_WINDOW * MAX_WINDOW * 256 + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bmf_cmd_t          cmd,
    output bmf_status_t            status,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic [NW_W-1:0]   nwin,
    bmf_out_if.source              results
);

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rdata_reg;
    logic              rvalid_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  div_reg;
    logic [7:0]        quot_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (rvalid_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(rdata_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg  <= acc_reg + ACC_W'(nwin >> 1);
            div_reg  <= ACC_W'({nwin, 7'd0});
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= div_reg)
            begin
                rem_reg  <= rem_reg - div_reg;
                quot_reg <= {quot_reg[6:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[6:0], 1'b0};
            end
            div_reg <= div_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= quot_reg;
            out_last_reg <= cmd.last;
        end
    end

    assign status.slot_free = !out_valid_reg || results.ready;
    assign results.valid    = out_valid_reg;
    assign results.filtered = out_data_reg;
    assign results.last     = out_last_reg;

endmodule
`default_nettype wire

>>> hdl/bmf_controller.sv
// ----------------------------------------------------------------------------
// bmf_controller
// Registers, raster counters and the sequencer of the window reads.
// ----------------------------------------------------------------------------
`default_nettype none
module bmf_controller
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_WINDOW   = 7,
    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS * MAX_WINDOW,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int NW_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    bmf_in_if.sink                 samples,
    bmf_cfg_if.sink                cfg,
    output bmf_cmd_t               cmd,
    input  wire bmf_status_t       status,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic [ADDR_W-1:0]      rd_addr,
    output logic [NW_W-1:0]        nwin
);

    localparam int WE_W  = $clog2(MAX_WIDTH + 1);
    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RM_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW    = $clog2(MAX_WINDOW + 1);
    localparam int CNT_W = 12 + WE_W + 3;

    bmf_state_t        state_reg, state_next;

    logic [10:0]       w_reg;
    logic [11:0]       h_reg;
    logic [2:0]        c_reg;
    logic [2:0]        s_reg;
    logic [23:0]       hw_reg;
    logic [WE_W+SW:0]  lagw_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  lag_reg;
    logic [1:0]        settle_reg;

    logic [CH_W-1:0]   in_chan_reg, out_chan_reg, ch_reg;
    logic [COL_W-1:0]  in_col_reg, out_col_reg, base_col_reg, cur_col_reg;
    logic [RM_W-1:0]   in_rowm_reg, out_rowm_reg, cur_rowm_reg;
    logic [11:0]       out_row_reg;
    logic [CNT_W-1:0]  in_cnt_reg, out_cnt_reg;
    logic              in_done_reg;
    logic [SW-1:0]     dim_reg, i_reg, j_reg;
    logic [NW_W-1:0]   nwin_reg;
    logic              last_reg;
    logic [2:0]        k_reg;

    logic [WE_W-1:0]   w_eff;
    logic [11:0]       h_eff;
    logic [2:0]        c_eff;
    logic [SW-1:0]     s_eff, lh, rh;
    logic              in_fire, wr_item, emit_go, in_win, is_last;
    logic [CNT_W-1:0]  in_cnt_inc, out_cnt_inc;
    logic [RM_W-1:0]   base_rowm;
    logic [COL_W-1:0]  base_col;

    always_comb
    begin
        if (w_reg == 11'd0)
            w_eff = WE_W'(1);
        else if (32'(w_reg) > MAX_WIDTH)
            w_eff = WE_W'(MAX_WIDTH);
        else
            w_eff = WE_W'(w_reg);
        h_eff = (h_reg == 12'd0) ? 12'd1 : h_reg;
        if (c_reg == 3'd0)
            c_eff = 3'd1;
        else if (32'(c_reg) > MAX_CHANNELS)
            c_eff = 3'(MAX_CHANNELS);
        else
            c_eff = c_reg;
        if (s_reg == 3'd0)
            s_eff = SW'(1);
        else if (32'(s_reg) > MAX_WINDOW)
            s_eff = SW'(MAX_WINDOW);
        else
            s_eff = SW'(s_reg);
        lh = s_eff >> 1;
        rh = s_eff - lh - SW'(1);
    end

    // image size and output lag, two multiply stages
    always_ff @(posedge clk)
    begin
        hw_reg    <= 24'(h_eff) * 24'(w_eff);
        lagw_reg  <= (WE_W+SW+1)'(rh) * ((WE_W+SW+1)'(w_eff) + (WE_W+SW+1)'(1));
        total_reg <= CNT_W'(hw_reg) * CNT_W'(c_eff);
        lag_reg   <= CNT_W'(lagw_reg) * CNT_W'(c_eff);
    end

    // hold samples off until size and lag have passed both multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= 2'd2;
        end
        else if (cfg.valid)
        begin
            settle_reg <= 2'd2;
        end
        else if (settle_reg != 2'd0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= 11'd640;
            h_reg <= 12'd480;
            c_reg <= 3'd1;
            s_reg <= 3'd3;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  w_reg <= cfg.data[10:0];
                REG_IMAGE_HEIGHT: h_reg <= cfg.data;
                REG_CHANNELS:     c_reg <= cfg.data[2:0];
                REG_WINDOW_SIZE:  s_reg <= cfg.data[2:0];
                default:          ;
            endcase
        end
    end

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == ST_IDLE) && (settle_reg == 2'd0);

    assign in_fire     = samples.valid && samples.ready;
    assign wr_item     = in_fire && !samples.drain && !in_done_reg;
    assign in_cnt_inc  = in_cnt_reg + CNT_W'(1);
    assign out_cnt_inc = out_cnt_reg + CNT_W'(1);
    assign emit_go     = wr_item ? (in_cnt_inc > lag_reg)
                       : (in_fire && in_done_reg && (out_cnt_reg < total_reg));
    assign is_last     = out_cnt_inc >= total_reg;

    assign in_win = (out_row_reg >= 12'(lh))
                 && ({1'b0, out_row_reg} + 13'(rh) < {1'b0, h_eff})
                 && (32'(out_col_reg) >= 32'(lh))
                 && (32'(out_col_reg) + 32'(rh) < 32'(w_eff));

    always_comb
    begin
        if (!in_win)
            base_rowm = out_rowm_reg;
        else if (32'(out_rowm_reg) >= 32'(lh))
            base_rowm = out_rowm_reg - RM_W'(lh);
        else
            base_rowm = RM_W'(32'(out_rowm_reg) + MAX_WINDOW - 32'(lh));
        base_col = in_win ? (out_col_reg - COL_W'(lh)) : out_col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_chan_reg  <= '0;
            in_col_reg   <= '0;
            in_rowm_reg  <= '0;
            in_cnt_reg   <= '0;
            in_done_reg  <= 1'b0;
            out_chan_reg <= '0;
            out_col_reg  <= '0;
            out_rowm_reg <= '0;
            out_row_reg  <= '0;
            out_cnt_reg  <= '0;
        end
        else if (cfg.valid && (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT
                 || cfg.index == REG_CHANNELS || cfg.index == REG_WINDOW_SIZE))
        begin
            in_chan_reg  <= '0;
            in_col_reg   <= '0;
            in_rowm_reg  <= '0;
            in_cnt_reg   <= '0;
            in_done_reg  <= 1'b0;
            out_chan_reg <= '0;
            out_col_reg  <= '0;
            out_rowm_reg <= '0;
            out_row_reg  <= '0;
            out_cnt_reg  <= '0;
        end
        else if (emit_go && is_last)
        begin
            in_chan_reg  <= '0;
            in_col_reg   <= '0;
            in_rowm_reg  <= '0;
            in_cnt_reg   <= '0;
            in_done_reg  <= 1'b0;
            out_chan_reg <= '0;
            out_col_reg  <= '0;
            out_rowm_reg <= '0;
            out_row_reg  <= '0;
            out_cnt_reg  <= '0;
        end
        else
        begin
            if (wr_item)
            begin
                in_cnt_reg <= in_cnt_inc;
                if (in_cnt_inc >= total_reg)
                    in_done_reg <= 1'b1;
                if (3'(in_chan_reg) + 3'd1 >= c_eff)
                begin
                    in_chan_reg <= '0;
                    if (32'(in_col_reg) + 1 >= 32'(w_eff))
                    begin
                        in_col_reg <= '0;
                        if (32'(in_rowm_reg) + 1 >= MAX_WINDOW)
                            in_rowm_reg <= '0;
                        else
                            in_rowm_reg <= in_rowm_reg + RM_W'(1);
                    end
                    else
                        in_col_reg <= in_col_reg + COL_W'(1);
                end
                else
                    in_chan_reg <= in_chan_reg + CH_W'(1);
            end
            if (emit_go)
            begin
                out_cnt_reg <= out_cnt_inc;
                if (3'(out_chan_reg) + 3'd1 >= c_eff)
                begin
                    out_chan_reg <= '0;
                    if (32'(out_col_reg) + 1 >= 32'(w_eff))
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + 12'd1;
                        if (32'(out_rowm_reg) + 1 >= MAX_WINDOW)
                            out_rowm_reg <= '0;
                        else
                            out_rowm_reg <= out_rowm_reg + RM_W'(1);
                    end
                    else
                        out_col_reg <= out_col_reg + COL_W'(1);
                end
                else
                    out_chan_reg <= out_chan_reg + CH_W'(1);
            end
        end
    end

    // window walk and divider step count
    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            ch_reg       <= out_chan_reg;
            base_col_reg <= base_col;
            cur_col_reg  <= base_col;
            cur_rowm_reg <= base_rowm;
            dim_reg      <= in_win ? s_eff : SW'(1);
            nwin_reg     <= in_win ? NW_W'(s_eff * s_eff) : NW_W'(1);
            last_reg     <= is_last;
            i_reg        <= '0;
            j_reg        <= '0;
        end
        else if (state_reg == ST_READ)
        begin
            if (j_reg == dim_reg - SW'(1))
            begin
                j_reg       <= '0;
                i_reg       <= i_reg + SW'(1);
                cur_col_reg <= base_col_reg;
                if (32'(cur_rowm_reg) + 1 >= MAX_WINDOW)
                    cur_rowm_reg <= '0;
                else
                    cur_rowm_reg <= cur_rowm_reg + RM_W'(1);
            end
            else
            begin
                j_reg       <= j_reg + SW'(1);
                cur_col_reg <= cur_col_reg + COL_W'(1);
            end
        end
        if (state_reg == ST_LOAD)
            k_reg <= '0;
        else if (state_reg == ST_DIV)
            k_reg <= k_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (emit_go) state_next = ST_READ;
            ST_READ:
                if (j_reg == dim_reg - SW'(1) && i_reg == dim_reg - SW'(1))
                    state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_DIV;
            ST_DIV:   if (k_reg == 3'(DIV_STEPS - 1)) state_next = ST_DONE;
            ST_DONE:  if (status.slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.last     = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_en   = wr_item;
                cmd.acc_clr = emit_go;
            end
            ST_READ:  cmd.rd_en    = 1'b1;
            ST_FLUSH: ;
            ST_LOAD:  cmd.div_load = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_DONE:  cmd.out_load = status.slot_free;
            default:  ;
        endcase
    end

    assign wr_addr = ADDR_W'((32'(in_rowm_reg) * MAX_WIDTH + 32'(in_col_reg)) * MAX_CHANNELS
                             + 32'(in_chan_reg));
    assign rd_addr = ADDR_W'((32'(cur_rowm_reg) * MAX_WIDTH + 32'(cur_col_reg)) * MAX_CHANNELS
                             + 32'(ch_reg));
    assign nwin    = nwin_reg;

endmodule
`default_nettype wire

>>> hdl/box_mean_filter_core.sv
// The time to a result is set by the single read port of the line store, which reads
// the whole window (one read on border pixels), and by the 8-step divider. One item at
// a time: an item that gives a result holds off further samples until that result is
// loaded into the output register; items that give none do not hold off the input.
// Samples are held off after a register write while size and lag settle.
// Reset clears counters and registers to their defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
// box_mean_filter_core
// Streaming two-dimensional box mean filter over interleaved 8-bit samples.
// ----------------------------------------------------------------------------
`default_nettype none
module box_mean_filter_core
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_CHANNELS = 4,
    parameter int MAX_WINDOW   = 7
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bmf_in_if.sink    samples,
    bmf_out_if.source results,
    bmf_cfg_if.sink   cfg
);

    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int NW_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

    bmf_cmd_t          cmd;
    bmf_status_t       status;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [NW_W-1:0]   nwin;

    bmf_controller #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .nwin    (nwin)
    );

    bmf_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_WINDOW   (MAX_WINDOW)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .wr_addr (wr_addr),
        .wr_data (samples.sample),
        .rd_addr (rd_addr),
        .nwin    (nwin),
        .results (results)
    );

endmodule
`default_nettype wire

>>> hdl/bmf_checker.sv
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks of the box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_mean_filter_core_defines.svh"
module bmf_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       cfg_valid,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_filtered
);

    `BMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `BMF_ASSERT_NOW(a_in_fall, $fell(in_ready), $past(in_valid) || $past(cfg_valid), "ready fell without a transfer")
    `BMF_ASSERT_NOW(a_out_rise, $rose(out_valid), !$past(in_ready), "result raised while accepting")
    `BMF_ASSERT_NEXT(a_out_data, out_valid && !out_ready, $stable(out_filtered), "result changed")

endmodule

bind box_mean_filter_core bmf_checker u_bmf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (samples.valid),
    .in_ready     (samples.ready),
    .cfg_valid    (cfg.valid),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_filtered (results.filtered)
);
`default_nettype wire

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for box_mean_filter_core. Directed table, two fixed shapes,
// then random images of random shape; every result transfer is checked against the
// table's expected value or a behavioural model of the windowed mean held in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb_top;
    import bmf_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXC = 4;
    localparam int MAXS = 7;
    localparam int STORE = MAXW * MAXC * MAXS;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 80;

    typedef struct {
        bit              cfg;
        logic [2:0]      idx;
        logic [11:0]     data;
        logic [7:0]      smp;
        bit              drn;
        bit              typed;
        logic [7:0]      ef;
        bit              el;
    } row_t;

    typedef struct {
        logic [7:0] filtered;
        bit         last;
    } pix_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   errors;

    bmf_in_if  in_ch();
    bmf_out_if out_ch();
    bmf_cfg_if cfg_ch();

    box_mean_filter_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .results (out_ch),
        .cfg     (cfg_ch)
    );

    // mean model state
    logic [7:0] pix_mem [STORE];
    int unsigned reg_w, reg_h, reg_c, reg_s;
    int unsigned wr_row, wr_col, wr_ch, wr_cnt;
    int unsigned rd_row, rd_col, rd_ch, rd_cnt;
    bit          img_full;
    pix_t        pending_pix[$];

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int unsigned mem_addr(int unsigned r, int unsigned c, int unsigned ch);
        return ((r % MAXS) * MAXW + (c % MAXW)) * MAXC + (ch % MAXC);
    endfunction

    function automatic void restart_image();
        wr_row = 0; wr_col = 0; wr_ch = 0; wr_cnt = 0;
        rd_row = 0; rd_col = 0; rd_ch = 0; rd_cnt = 0;
        img_full = 0;
    endfunction

    function automatic void reg_write(logic [2:0] idx, logic [11:0] v);
        case (idx)
            REG_IMAGE_WIDTH:  reg_w = v[10:0];
            REG_IMAGE_HEIGHT: reg_h = v;
            REG_CHANNELS:     reg_c = v[2:0];
            REG_WINDOW_SIZE:  reg_s = v[2:0];
            default: return;
        endcase
        restart_image();
    endfunction

    function automatic pix_t window_out(int unsigned W, int unsigned H, int unsigned C,
                                        int unsigned S, int unsigned N);
        int unsigned lh, rh, sum, n;
        pix_t p;
        lh = S / 2;
        rh = S - lh - 1;
        if (rd_row >= lh && rd_row + rh < H && rd_col >= lh && rd_col + rh < W) begin
            sum = 0;
            n = S * S;
            for (int unsigned i = rd_row - lh; i <= rd_row + rh; i++)
                for (int unsigned j = rd_col - lh; j <= rd_col + rh; j++)
                    sum += pix_mem[mem_addr(i, j, rd_ch)];
            p.filtered = 8'((sum + n / 2) / n);
        end else begin
            p.filtered = pix_mem[mem_addr(rd_row, rd_col, rd_ch)];
        end
        rd_cnt++;
        p.last = rd_cnt >= N;
        if (++rd_ch >= C) begin
            rd_ch = 0;
            if (++rd_col >= W) begin
                rd_col = 0;
                rd_row++;
            end
        end
        if (rd_cnt >= N)
            restart_image();
        return p;
    endfunction

    function automatic bit mean_step(logic [7:0] s, bit d, output pix_t p);
        int unsigned W, H, C, S, N, L, rh;
        W = clampu(reg_w, 1, MAXW);
        H = reg_h < 1 ? 1 : reg_h;
        C = clampu(reg_c, 1, MAXC);
        S = clampu(reg_s, 1, MAXS);
        rh = S - S / 2 - 1;
        N = H * W * C;
        L = (rh * W + rh) * C;
        if (!d && !img_full) begin
            pix_mem[mem_addr(wr_row, wr_col, wr_ch)] = s;
            if (++wr_ch >= C) begin
                wr_ch = 0;
                if (++wr_col >= W) begin
                    wr_col = 0;
                    wr_row++;
                end
            end
            wr_cnt++;
            if (wr_cnt >= N)
                img_full = 1;
            if (wr_cnt > L) begin
                p = window_out(W, H, C, S, N);
                return 1;
            end
            return 0;
        end
        if (img_full && rd_cnt < N) begin
            p = window_out(W, H, C, S, N);
            return 1;
        end
        return 0;
    endfunction

    // clock and cycle limit
    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side stalls
    bit   burst_mode;
    int   stall_left;
    initial begin
        out_ch.ready = 0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready = 0;
            end else begin
                out_ch.ready = 1;
                if (!burst_mode) begin
                    int r;
                    r = $urandom_range(0, 99);
                    if (r >= 95)
                        stall_left = $urandom_range(10, 40);
                    else if (r >= 70)
                        stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_pix.size() == 0) begin
                $display("%0t: unexpected transfer filtered=%0d last=%0d",
                         $realtime, out_ch.filtered, out_ch.last);
                errors++;
            end else begin
                pix_t e;
                e = pending_pix.pop_front();
                if (out_ch.filtered !== e.filtered) begin
                    $display("%0t: filtered expected %0d actual %0d",
                             $realtime, e.filtered, out_ch.filtered);
                    errors++;
                end
                if (out_ch.last !== e.last) begin
                    $display("%0t: last expected %0d actual %0d",
                             $realtime, e.last, out_ch.last);
                    errors++;
                end
            end
        end
    end

    task automatic idle_gap();
        int r, g;
        g = 0;
        if (!burst_mode) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                g = $urandom_range(10, 40);
            else if (r >= 65)
                g = $urandom_range(1, 3);
        end
        if (g > 0) begin
            in_ch.valid = 0;
            repeat (g) @(negedge clk);
        end
    endtask

    // drives one sample transfer; at entry and exit we sit just after a falling edge
    task automatic send_item(logic [7:0] s, bit d, bit typed, pix_t tp);
        pix_t p;
        idle_gap();
        in_ch.valid = 1;
        in_ch.sample = s;
        in_ch.drain = d;
        do @(posedge clk); while (!in_ch.ready);
        if (mean_step(s, d, p))
            pending_pix.push_back(typed ? tp : p);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid = 0;
        while (pending_pix.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] v);
        cfg_ch.valid = 1;
        cfg_ch.index = idx;
        cfg_ch.data = v;
        do @(posedge clk); while (!cfg_ch.ready);
        reg_write(idx, v);
        @(negedge clk);
        cfg_ch.valid = 0;
    endtask

    task automatic set_shape(logic [11:0] w, logic [11:0] h, logic [11:0] c, logic [11:0] s);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CHANNELS, c);
        write_reg(REG_WINDOW_SIZE, s);
    endtask

    function automatic logic [7:0] rand_pix();
        int r;
        r = $urandom_range(0, 9);
        return r == 0 ? 8'd0 : (r == 1 ? 8'd255 : 8'($urandom));
    endfunction

    row_t dir_rows[] = '{
        '{1, REG_IMAGE_WIDTH,  12'd1, 8'd0, 0, 0, 8'd0, 0},
        '{1, REG_IMAGE_HEIGHT, 12'd1, 8'd0, 0, 0, 8'd0, 0},
        '{1, REG_CHANNELS,     12'd1, 8'd0, 0, 0, 8'd0, 0},
        '{1, REG_WINDOW_SIZE,  12'd1, 8'd0, 0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd255, 0, 1, 8'd255, 1},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   0, 1, 8'd0,   1},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd77,  1, 0, 8'd0,   0},
        '{1, REG_IMAGE_WIDTH,  12'd2, 8'd0, 0, 0, 8'd0, 0},
        '{1, REG_IMAGE_HEIGHT, 12'd2, 8'd0, 0, 0, 8'd0, 0},
        '{1, REG_WINDOW_SIZE,  12'd2, 8'd0, 0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd255, 0, 1, 8'd255, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd255, 0, 1, 8'd255, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd255, 0, 1, 8'd255, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   0, 1, 8'd191, 1},
        '{1, REG_IMAGE_WIDTH,  12'd3, 8'd0, 0, 0, 8'd0, 0},
        '{1, REG_IMAGE_HEIGHT, 12'd3, 8'd0, 0, 0, 8'd0, 0},
        '{1, REG_WINDOW_SIZE,  12'd3, 8'd0, 0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd10,  0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd200, 0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd31,  0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd255, 0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd1,   0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd128, 0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd99,  0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd254, 0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd42,  0, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1, 0, 8'd0, 0},
        '{0, REG_IMAGE_WIDTH,  12'd0, 8'd0,   1, 0, 8'd0, 0}
    };

    initial begin
        int items, W, H, C, S, N, L, rh;
        pix_t tp;
        logic [11:0] cw, ch, cc, cs;
        cycles = 0;
        errors = 0;
        burst_mode = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.sample = '0;
        in_ch.drain = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = REG_IMAGE_WIDTH;
        cfg_ch.data = '0;
        reg_w = 640; reg_h = 480; reg_c = 1; reg_s = 3;
        restart_image();
        repeat (8) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg) begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                tp.filtered = dir_rows[i].ef;
                tp.last = dir_rows[i].el;
                send_item(dir_rows[i].smp, dir_rows[i].drn, dir_rows[i].typed, tp);
            end
        end

        // widest and tallest image, all channels; abandoned part way through
        set_shape(12'd1024, 12'd4095, 12'd4, 12'd1);
        for (int k = 0; k < 60; k++)
            send_item(rand_pix(), 0, 0, tp);
        set_shape(12'd2047, 12'd2, 12'd7, 12'd0);
        for (int k = 0; k < 20; k++)
            send_item(rand_pix(), 0, 0, tp);

        items = 80;
        while (items < 800) begin
            cw = $urandom_range(0, 9) == 0 ? 12'd0 : 12'($urandom_range(1, 8));
            ch = $urandom_range(0, 9) == 0 ? 12'd0 : 12'($urandom_range(1, 7));
            cc = 12'($urandom_range(0, 7));
            cs = 12'($urandom_range(0, 7));
            set_shape(cw, ch, cc, cs);
            W = clampu(reg_w, 1, MAXW);
            H = reg_h < 1 ? 1 : reg_h;
            C = clampu(reg_c, 1, MAXC);
            S = clampu(reg_s, 1, MAXS);
            rh = S - S / 2 - 1;
            N = W * H * C;
            L = (rh * W + rh) * C;
            repeat ($urandom_range(1, 3)) begin
                burst_mode = $urandom_range(0, 3) == 0;
                for (int k = 0; k < N; k++) begin
                    if ($urandom_range(0, 99) < 8) begin
                        send_item(rand_pix(), 1, 0, tp);
                        items++;
                    end
                    send_item(rand_pix(), 0, 0, tp);
                    items++;
                end
                if ($urandom_range(0, 19) == 0)
                    break;
                for (int k = 0; k < L + $urandom_range(0, 2); k++) begin
                    send_item(rand_pix(), $urandom_range(0, 3) != 0, 0, tp);
                    items++;
                end
            end
        end
        burst_mode = 0;

        in_ch.valid = 0;
        while (pending_pix.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
